FILE: hw/rtl/mm_pkg.sv
// Shared constants, types and helpers for the matrix multiply block.
// No dependencies; every other file of the block except mm_ram refers to this package.
`timescale 1ns / 1ps

package mm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int VALUE_BITS = 16;

   localparam int IDX_BITS   = 3;
   localparam int DIM_BITS   = 4;
   localparam int OUT_BITS   = 36;
   localparam int PROD_BITS  = 2 * VALUE_BITS;
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Request codes.
   localparam logic [1:0] REQ_LOAD_A  = 2'd0;
   localparam logic [1:0] REQ_LOAD_B  = 2'd1;
   localparam logic [1:0] REQ_COMPUTE = 2'd2;
   localparam logic [1:0] REQ_NONE    = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_INNER_DIM = 2'd1;
   localparam logic [1:0] REG_COLS_B    = 2'd2;
   localparam logic [1:0] REG_UNUSED    = 2'd3;

   // Control that travels alongside each multiply-accumulate step.
   typedef struct packed {
      logic                first;
      logic                fin;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
      logic                last;
   } tag_type;

   // Out-of-range dimensions are used as the nearest legal value.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
      logic [DIM_BITS-1:0] r;
      if (d == '0) begin
         r = DIM_BITS'(1);
      end else if (d > DIM_BITS'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/mm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module mm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mm_seq.sv
// Index sequencer: walks row, column and inner index and issues store reads.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [mm_pkg::DIM_BITS-1:0]      num_rows,
   input  logic [mm_pkg::DIM_BITS-1:0]      num_inner,
   input  logic [mm_pkg::DIM_BITS-1:0]      num_cols,
   output logic                             running,
   output logic                             issue_valid,
   output mm_pkg::tag_type                  issue_tag,
   output logic [mm_pkg::ADDR_BITS-1:0]     addr_a,
   output logic [mm_pkg::ADDR_BITS-1:0]     addr_b
);

   logic                          run_ff, run_in;
   logic [mm_pkg::IDX_BITS-1:0]   i_ff, i_in;
   logic [mm_pkg::IDX_BITS-1:0]   j_ff, j_in;
   logic [mm_pkg::IDX_BITS-1:0]   k_ff, k_in;
   logic                          k_end, j_end, i_end;

   assign k_end = {1'b0, k_ff} == num_inner - mm_pkg::DIM_BITS'(1);
   assign j_end = {1'b0, j_ff} == num_cols  - mm_pkg::DIM_BITS'(1);
   assign i_end = {1'b0, i_ff} == num_rows  - mm_pkg::DIM_BITS'(1);

   always_comb begin
      run_in = run_ff;
      i_in   = i_ff;
      j_in   = j_ff;
      k_in   = k_ff;
      if (run_ff) begin
         if (!k_end) begin
            k_in = k_ff + 1'b1;
         end else begin
            k_in = '0;
            if (!j_end) begin
               j_in = j_ff + 1'b1;
            end else begin
               j_in = '0;
               if (!i_end) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  i_in   = '0;
                  run_in = 1'b0;
               end
            end
         end
      end else if (go) begin
         run_in = 1'b1;
         i_in   = '0;
         j_in   = '0;
         k_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         i_ff   <= '0;
         j_ff   <= '0;
         k_ff   <= '0;
      end else begin
         run_ff <= run_in;
         i_ff   <= i_in;
         j_ff   <= j_in;
         k_ff   <= k_in;
      end
   end

   assign running         = run_ff;
   assign issue_valid     = run_ff;
   assign issue_tag.first = (k_ff == '0);
   assign issue_tag.fin   = k_end;
   assign issue_tag.row   = i_ff;
   assign issue_tag.col   = j_ff;
   assign issue_tag.last  = i_end && j_end;

   // A[i][k] and B[k][j], stored row-major.
   assign addr_a = mm_pkg::ADDR_BITS'(int'(i_ff) * mm_pkg::MAX_DIM + int'(k_ff));
   assign addr_b = mm_pkg::ADDR_BITS'(int'(k_ff) * mm_pkg::MAX_DIM + int'(j_ff));

endmodule

FILE: hw/rtl/mm_mac.sv
// Multiply-accumulate datapath: product register, accumulator and result register.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               issue_valid,
   input  mm_pkg::tag_type                    issue_tag,
   input  logic [mm_pkg::VALUE_BITS-1:0]      data_a,
   input  logic [mm_pkg::VALUE_BITS-1:0]      data_b,
   output logic                               out_valid,
   output logic [mm_pkg::IDX_BITS-1:0]        out_row,
   output logic [mm_pkg::IDX_BITS-1:0]        out_col,
   output logic signed [mm_pkg::OUT_BITS-1:0] out_value,
   output logic                               out_last
);

   logic                                v1_ff, v2_ff, v3_ff;
   mm_pkg::tag_type                     tag1_ff, tag2_ff, tag3_ff;
   logic signed [mm_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [mm_pkg::OUT_BITS-1:0]  acc_ff, acc_in, prod_ext;

   // Sign-extend the product to the accumulator width.
   assign prod_ext = mm_pkg::OUT_BITS'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (v2_ff) begin
         acc_in = tag2_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && tag2_ff.fin;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= issue_tag;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      prod_ff <= signed'(data_a) * signed'(data_b);
      acc_ff  <= acc_in;
   end

   assign out_valid = v3_ff;
   assign out_row   = tag3_ff.row;
   assign out_col   = tag3_ff.col;
   assign out_value = acc_ff;
   assign out_last  = tag3_ff.last;

endmodule

FILE: hw/rtl/matrix_multiply.sv
// Top level of the matrix multiply block: register port, element stores and datapath.
// Depends on mm_pkg, mm_ram, mm_seq and mm_mac.
`timescale 1ns / 1ps

// Matrix multiply C = A x B on signed Q8.8 elements, with each element of C
// delivered as a full-precision signed Q20.16 sum in 36 bits. A request is
// accepted on a rising edge with start high and busy low. A load of A or B
// writes one element in that single cycle and never raises busy. A compute
// holds busy from the edge that accepts it until its last elements are read,
// taking each size after clamping to 1..8, because one multiply-accumulate
// unit reads one element of A and one of B per cycle from the two element
// memories. Results pass the store read, product and accumulator registers,
// one element of C per inner_dim products, in row-major order, with rsp_last set on
// the final one. Each result is shown for exactly one cycle with rsp_valid high;
// there is no way to hold a result off, so the receiver must take every transfer
// as it comes. The dimension registers are read continuously and should only be
// written while no compute is running or draining. Every element of A and B that
// a compute reads must have been loaded first; the stores are not cleared.

module matrix_multiply (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [mm_pkg::IDX_BITS-1:0]         req_row,
   input  logic [mm_pkg::IDX_BITS-1:0]         req_col,
   input  logic signed [mm_pkg::VALUE_BITS-1:0] req_value,

   output logic                                rsp_valid,
   output logic [mm_pkg::IDX_BITS-1:0]         rsp_out_row,
   output logic [mm_pkg::IDX_BITS-1:0]         rsp_out_col,
   output logic signed [mm_pkg::OUT_BITS-1:0]  rsp_out_value,
   output logic                                rsp_last,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mm_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [mm_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [mm_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [mm_pkg::DIM_BITS-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic                        csr_write;
   logic [1:0]                  csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mm_pkg::DIM_BITS'(mm_pkg::MAX_DIM);
         inner_dim_ff <= mm_pkg::DIM_BITS'(mm_pkg::MAX_DIM);
         cols_b_ff    <= mm_pkg::DIM_BITS'(mm_pkg::MAX_DIM);
      end else if (csr_write) begin
         unique case (csr_index)
            mm_pkg::REG_ROWS_A:    rows_a_ff    <= pwdata[mm_pkg::DIM_BITS-1:0];
            mm_pkg::REG_INNER_DIM: inner_dim_ff <= pwdata[mm_pkg::DIM_BITS-1:0];
            mm_pkg::REG_COLS_B:    cols_b_ff    <= pwdata[mm_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mm_pkg::REG_ROWS_A:    prdata = mm_pkg::CSR_DATA_BITS'(rows_a_ff);
         mm_pkg::REG_INNER_DIM: prdata = mm_pkg::CSR_DATA_BITS'(inner_dim_ff);
         mm_pkg::REG_COLS_B:    prdata = mm_pkg::CSR_DATA_BITS'(cols_b_ff);
         default:               prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   logic                          accept;
   logic                          in_range;
   logic                          load_a, load_b, go;
   logic [mm_pkg::ADDR_BITS-1:0]  wr_addr;
   logic [mm_pkg::VALUE_BITS-1:0] wr_data;

   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_row} < mm_pkg::DIM_BITS'(mm_pkg::MAX_DIM)) &&
                     ({1'b0, req_col} < mm_pkg::DIM_BITS'(mm_pkg::MAX_DIM));
   assign load_a   = accept && in_range && (req_type == mm_pkg::REQ_LOAD_A);
   assign load_b   = accept && in_range && (req_type == mm_pkg::REQ_LOAD_B);
   assign go       = accept && (req_type == mm_pkg::REQ_COMPUTE);
   assign wr_addr  = mm_pkg::ADDR_BITS'(int'(req_row) * mm_pkg::MAX_DIM + int'(req_col));
   assign wr_data  = req_value;

   // ------------------------------------------------------------------
   // Sequencer. Loads are refused while it runs, so a write and a read of
   // the same entry never meet in one cycle; a compute accepted right after
   // a load already sees the written value.
   // ------------------------------------------------------------------
   logic                          running;
   logic                          issue_valid;
   mm_pkg::tag_type               issue_tag;
   logic [mm_pkg::ADDR_BITS-1:0]  addr_a, addr_b;

   mm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .num_rows    (mm_pkg::clamp_dim(rows_a_ff)),
      .num_inner   (mm_pkg::clamp_dim(inner_dim_ff)),
      .num_cols    (mm_pkg::clamp_dim(cols_b_ff)),
      .running     (running),
      .issue_valid (issue_valid),
      .issue_tag   (issue_tag),
      .addr_a      (addr_a),
      .addr_b      (addr_b)
   );

   assign busy = running;

   // ------------------------------------------------------------------
   // Element stores for A and B.
   // ------------------------------------------------------------------
   logic [mm_pkg::VALUE_BITS-1:0] data_a, data_b;

   mm_ram #(
      .WIDTH (mm_pkg::VALUE_BITS),
      .DEPTH (mm_pkg::DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_a),
      .rd_data (data_a)
   );

   mm_ram #(
      .WIDTH (mm_pkg::VALUE_BITS),
      .DEPTH (mm_pkg::DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_b),
      .rd_data (data_b)
   );

   // ------------------------------------------------------------------
   // Multiply-accumulate and result register. Tags ride with the data, so
   // a new compute may start while the previous one is still draining.
   // ------------------------------------------------------------------
   mm_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_tag   (issue_tag),
      .data_a      (data_a),
      .data_b      (data_b),
      .out_valid   (rsp_valid),
      .out_row     (rsp_out_row),
      .out_col     (rsp_out_col),
      .out_value   (rsp_out_value),
      .out_last    (rsp_last)
   );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply: element loads, products and register settings.
// Depends on mm_pkg and the matrix_multiply RTL; the scoreboard class lives in this file too.

typedef struct {
   logic [mm_pkg::IDX_BITS-1:0] row;
   logic [mm_pkg::IDX_BITS-1:0] col;
   logic [mm_pkg::OUT_BITS-1:0] value;
   logic                        last;
} c_elem_type;

class product_board;
   logic signed [mm_pkg::VALUE_BITS-1:0] elem_a [mm_pkg::DEPTH];
   logic signed [mm_pkg::VALUE_BITS-1:0] elem_b [mm_pkg::DEPTH];
   bit                                   loaded_a [mm_pkg::DEPTH];
   bit                                   loaded_b [mm_pkg::DEPTH];
   logic [mm_pkg::DIM_BITS-1:0]          dim_reg [3];
   c_elem_type                           pending [$];
   int                                   errors;
   int                                   products;
   int                                   elements;

   function new();
      for (int i = 0; i < mm_pkg::DEPTH; i++) begin
         elem_a[i]   = '0;
         elem_b[i]   = '0;
         loaded_a[i] = 1'b0;
         loaded_b[i] = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         dim_reg[i] = mm_pkg::DIM_BITS'(mm_pkg::MAX_DIM);
      end
      errors   = 0;
      products = 0;
      elements = 0;
   endfunction

   function void set_dim(input logic [1:0] index, input logic [mm_pkg::DIM_BITS-1:0] value);
      dim_reg[index] = value;
   endfunction

   // Zero is used as one and anything past the array size as the array size.
   function int unsigned eff_dim(input logic [1:0] index);
      if (dim_reg[index] == '0) begin
         return 1;
      end
      if (dim_reg[index] > mm_pkg::MAX_DIM) begin
         return mm_pkg::MAX_DIM;
      end
      return dim_reg[index];
   endfunction

   function bit can_compute();
      int unsigned nr, nk, nc;
      nr = eff_dim(mm_pkg::REG_ROWS_A);
      nk = eff_dim(mm_pkg::REG_INNER_DIM);
      nc = eff_dim(mm_pkg::REG_COLS_B);
      for (int unsigned i = 0; i < nr; i++) begin
         for (int unsigned k = 0; k < nk; k++) begin
            if (!loaded_a[i * mm_pkg::MAX_DIM + k]) return 1'b0;
         end
      end
      for (int unsigned k = 0; k < nk; k++) begin
         for (int unsigned j = 0; j < nc; j++) begin
            if (!loaded_b[k * mm_pkg::MAX_DIM + j]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Finds an entry that the next product would read but that was never loaded.
   function bit missing_entry(output bit is_b, output int unsigned idx);
      int unsigned nr, nk, nc;
      nr   = eff_dim(mm_pkg::REG_ROWS_A);
      nk   = eff_dim(mm_pkg::REG_INNER_DIM);
      nc   = eff_dim(mm_pkg::REG_COLS_B);
      is_b = 1'b0;
      idx  = 0;
      for (int unsigned i = 0; i < nr; i++) begin
         for (int unsigned k = 0; k < nk; k++) begin
            if (!loaded_a[i * mm_pkg::MAX_DIM + k]) begin
               idx = i * mm_pkg::MAX_DIM + k;
               return 1'b1;
            end
         end
      end
      for (int unsigned k = 0; k < nk; k++) begin
         for (int unsigned j = 0; j < nc; j++) begin
            if (!loaded_b[k * mm_pkg::MAX_DIM + j]) begin
               is_b = 1'b1;
               idx  = k * mm_pkg::MAX_DIM + j;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function void note_request(input logic [1:0] kind,
                              input logic [mm_pkg::IDX_BITS-1:0] row,
                              input logic [mm_pkg::IDX_BITS-1:0] col,
                              input logic signed [mm_pkg::VALUE_BITS-1:0] value);
      int unsigned nr, nk, nc, idx;
      longint      acc;
      c_elem_type  e;
      idx = row * mm_pkg::MAX_DIM + col;
      case (kind)
         mm_pkg::REQ_LOAD_A: begin
            elem_a[idx]   = value;
            loaded_a[idx] = 1'b1;
         end
         mm_pkg::REQ_LOAD_B: begin
            elem_b[idx]   = value;
            loaded_b[idx] = 1'b1;
         end
         mm_pkg::REQ_COMPUTE: begin
            nr = eff_dim(mm_pkg::REG_ROWS_A);
            nk = eff_dim(mm_pkg::REG_INNER_DIM);
            nc = eff_dim(mm_pkg::REG_COLS_B);
            products++;
            for (int unsigned i = 0; i < nr; i++) begin
               for (int unsigned j = 0; j < nc; j++) begin
                  acc = 0;
                  for (int unsigned k = 0; k < nk; k++) begin
                     acc += longint'(elem_a[i * mm_pkg::MAX_DIM + k]) *
                            longint'(elem_b[k * mm_pkg::MAX_DIM + j]);
                  end
                  e.row   = mm_pkg::IDX_BITS'(i);
                  e.col   = mm_pkg::IDX_BITS'(j);
                  e.value = acc[mm_pkg::OUT_BITS-1:0];
                  e.last  = (i == nr - 1) && (j == nc - 1);
                  pending.push_back(e);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function void check_element(input logic [mm_pkg::IDX_BITS-1:0] row,
                               input logic [mm_pkg::IDX_BITS-1:0] col,
                               input logic [mm_pkg::OUT_BITS-1:0] value,
                               input logic last);
      c_elem_type e;
      if (pending.size() == 0) begin
         $error("unexpected result element at row %0d col %0d", row, col);
         errors++;
         return;
      end
      e = pending.pop_front();
      elements++;
      if (row !== e.row) begin
         $error("out_row mismatch: expected %0d, got %0d", e.row, row);
         errors++;
      end
      if (col !== e.col) begin
         $error("out_col mismatch: expected %0d, got %0d", e.col, col);
         errors++;
      end
      if (value !== e.value) begin
         $error("out_value mismatch: expected %0d, got %0d", $signed(e.value), $signed(value));
         errors++;
      end
      if (last !== e.last) begin
         $error("last mismatch: expected %0d, got %0d", e.last, last);
         errors++;
      end
   endfunction
endclass

module tb;
   import mm_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 4000;
   // Results trail the element reads through the pipeline; these idle cycles cover its tail.
   localparam int SETTLE_CYCLES = 8;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_type;
   logic [IDX_BITS-1:0]           req_row;
   logic [IDX_BITS-1:0]           req_col;
   logic signed [VALUE_BITS-1:0]  req_value;
   logic                          rsp_valid;
   logic [IDX_BITS-1:0]           rsp_out_row;
   logic [IDX_BITS-1:0]           rsp_out_col;
   logic signed [OUT_BITS-1:0]    rsp_out_value;
   logic                          rsp_last;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [CSR_ADDR_BITS-1:0]      paddr;
   logic [CSR_DATA_BITS-1:0]      pwdata;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   product_board board;
   int           cycles;
   int           items_sent;
   int           settings_used;

   matrix_multiply DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #10 clock = ~clock;

   // A run that is still going at this count has hung somewhere.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The block cannot hold results off, so every cycle with rsp_valid high is a
   // transfer that must be checked at the edge that ends it.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         board.check_element(rsp_out_row, rsp_out_col, rsp_out_value, rsp_last);
      end
   end

   // Drives one request from the falling edge and holds it until the block takes
   // it, which is the rising edge where start is high and busy is low. The
   // request stays on the port until the next falling edge; whatever runs next
   // either replaces it or lowers start there.
   task automatic send_item(input logic [1:0] kind, input logic [IDX_BITS-1:0] r,
                            input logic [IDX_BITS-1:0] c, input logic [VALUE_BITS-1:0] v);
      @(negedge clock);
      start     <= 1'b1;
      req_type  <= kind;
      req_row   <= r;
      req_col   <= c;
      req_value <= v;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_request(kind, r, c, v);
      if (kind != REQ_NONE) items_sent++;
   endtask

   // Idle cycles scramble the payload so that nothing depends on a stale request.
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start     <= 1'b0;
         req_type  <= 2'($urandom());
         req_row   <= IDX_BITS'($urandom());
         req_col   <= IDX_BITS'($urandom());
         req_value <= VALUE_BITS'($urandom());
      end
   endtask

   // Mostly back-to-back or short gaps, with the odd long one; none at all when quiet.
   function automatic int gap_len(input bit quiet);
      int sel;
      if (quiet) return 0;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Weighted toward the Q8.8 extremes so that large products show up often.
   function automatic logic [VALUE_BITS-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) return 16'h7FFF;
      if (sel < 20) return 16'h8000;
      if (sel < 25) return 16'h0000;
      if (sel < 30) return 16'hFFFF;
      if (sel < 35) return 16'h0001;
      return VALUE_BITS'($urandom());
   endfunction

   // Holds start low until every expected element has arrived, lets the pipeline
   // tail run out, and then waits for busy to drop.
   task automatic settle();
      int waited;
      waited = 0;
      idle_cycles(1);
      while (board.pending.size() != 0 && waited < DRAIN_LIMIT) begin
         idle_cycles(1);
         waited++;
      end
      idle_cycles(SETTLE_CYCLES);
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // One register write followed by a read back of the same register. Each
   // access is a setup phase and then an access phase that ends when pready is high.
   task automatic csr_write(input logic [1:0] index, input logic [DIM_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] rd;
      logic [CSR_ADDR_BITS-1:0] addr;
      addr = CSR_ADDR_BITS'({index, 2'b00});
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= {28'($urandom()), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      board.set_dim(index, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      psel    <= 1'b1;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd[DIM_BITS-1:0] !== value) begin
         $error("register %0d read back mismatch: expected %0d, got %0d",
                index, value, rd[DIM_BITS-1:0]);
         board.errors++;
      end
   endtask

   // The dimensions feed a running compute directly, so they only change once
   // the block has gone quiet.
   task automatic apply_dims(input logic [DIM_BITS-1:0] nr, input logic [DIM_BITS-1:0] nk,
                             input logic [DIM_BITS-1:0] nc);
      settle();
      csr_write(REG_ROWS_A, nr);
      csr_write(REG_INNER_DIM, nk);
      csr_write(REG_COLS_B, nc);
      settings_used++;
   endtask

   // Random traffic under the current setting. Loads favor entries the next
   // product still needs, so products keep happening; the rest are scattered
   // over the whole store, and a few requests carry the unused code.
   task automatic random_phase(input int count, input bit quiet, input bit pause_mid);
      int          sent;
      int          sel;
      bit          is_b;
      int unsigned idx;
      sent = 0;
      while (sent < count) begin
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            send_item(REQ_NONE, IDX_BITS'($urandom()), IDX_BITS'($urandom()), pick_value());
         end else if (sel < 32 && board.can_compute()) begin
            send_item(REQ_COMPUTE, IDX_BITS'($urandom()), IDX_BITS'($urandom()),
                      VALUE_BITS'($urandom()));
            sent++;
         end else begin
            if (board.missing_entry(is_b, idx) && $urandom_range(0, 3) != 0) begin
               send_item(is_b ? REQ_LOAD_B : REQ_LOAD_A, IDX_BITS'(idx / MAX_DIM),
                         IDX_BITS'(idx % MAX_DIM), pick_value());
            end else begin
               send_item($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A,
                         IDX_BITS'($urandom()), IDX_BITS'($urandom()), pick_value());
            end
            sent++;
         end
         // Halfway through, the sender waits for the block to drain completely.
         if (pause_mid && sent == count / 2) begin
            settle();
         end
         idle_cycles(gap_len(quiet));
      end
   endtask

   initial begin
      board         = new();
      cycles        = 0;
      items_sent    = 0;
      settings_used = 0;
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = REQ_NONE;
      req_row       = '0;
      req_col       = '0;
      req_value     = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on 2x2 matrices: full-scale values of both signs, an
      // ignored request code that must not touch the store, loads at the top
      // corner of the store, and a product repeated after reloading entries.
      apply_dims(4'd2, 4'd2, 4'd2);
      send_item(REQ_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
      send_item(REQ_LOAD_A, 3'd0, 3'd1, 16'h8000);
      send_item(REQ_LOAD_A, 3'd1, 3'd0, 16'h8000);
      send_item(REQ_LOAD_A, 3'd1, 3'd1, 16'h7FFF);
      send_item(REQ_LOAD_B, 3'd0, 3'd0, 16'h8000);
      send_item(REQ_LOAD_B, 3'd0, 3'd1, 16'h7FFF);
      send_item(REQ_LOAD_B, 3'd1, 3'd0, 16'h8000);
      send_item(REQ_LOAD_B, 3'd1, 3'd1, 16'h8000);
      send_item(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
      send_item(REQ_NONE, 3'd0, 3'd0, 16'h1234);
      send_item(REQ_LOAD_A, 3'd7, 3'd7, 16'hFFFF);
      send_item(REQ_LOAD_B, 3'd7, 3'd7, 16'h0001);
      send_item(REQ_LOAD_A, 3'd0, 3'd0, 16'h0000);
      send_item(REQ_LOAD_B, 3'd1, 3'd1, 16'hFFFF);
      send_item(REQ_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
      idle_cycles(3);

      // Random part over several settings, including the smallest, the
      // largest result count and register values that need clamping.
      apply_dims(4'd1, 4'd1, 4'd1);
      random_phase(12, 1'b0, 1'b0);
      apply_dims(4'd8, 4'd1, 4'd8);
      random_phase(16, 1'b0, 1'b0);
      apply_dims(4'd0, 4'd15, 4'd0);
      random_phase(12, 1'b1, 1'b0);
      apply_dims(4'd3, 4'd4, 4'd5);
      random_phase(17, 1'b0, 1'b1);
      apply_dims(4'd15, 4'd2, 4'd15);
      random_phase(16, 1'b0, 1'b0);
      apply_dims(DIM_BITS'($urandom_range(0, 4)), DIM_BITS'($urandom_range(1, 9)),
                 DIM_BITS'($urandom_range(0, 4)));
      random_phase(16, 1'b0, 1'b0);

      settle();
      if (board.pending.size() != 0) begin
         $error("%0d result elements never arrived", board.pending.size());
         board.errors++;
      end

      $display("Run covered %0d load and product transfers, %0d products and %0d checked",
               items_sent, board.products, board.elements);
      $display("result elements across %0d dimension settings.", settings_used);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
